@@ src/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CFR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CFR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/cfr_pkg.sv @@
package cfr_pkg;

    // Fixed formats: Q1.15 samples and coefficients, Q2.30 products
    localparam int SMP_W  = 16;
    localparam int PROD_W = 2 * SMP_W;
    localparam int FRAC   = 15;
    localparam int NCOEF  = 8;
    localparam int CIDX_W = 3;

    typedef logic signed [SMP_W-1:0]  t_sample;
    typedef logic signed [PROD_W-1:0] t_prod;

    typedef struct packed {
        logic signed [SMP_W-1:0] sample_in;
        logic                    block_end;
    } t_in_item;

    typedef struct packed {
        logic signed [SMP_W-1:0] sample_out;
        logic                    clipped;
        logic                    block_end_out;
    } t_out_item;

    // Tag that travels beside the data through the sum pipeline
    typedef struct packed {
        logic valid;
        logic last;
    } t_tag;

endpackage

@@ src/cfr_stream_if.sv @@
interface cfr_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ src/cfr_cell.sv @@
module cfr_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_step,
    input  logic           i_clear,
    input  cfr_pkg::t_sample i_coef,
    input  cfr_pkg::t_sample i_x,
    output cfr_pkg::t_sample o_x,
    output cfr_pkg::t_prod   o_prod
);
    import cfr_pkg::*;

    t_sample r_x;
    t_prod   r_prod;

    // Window sample: takes the neighbor's sample on a step, zeroed on the block's last flush step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0;
        end else if (i_step) begin
            r_x <= i_clear ? '0 : i_x;
        end
    end

    // Tap product on the shifted window
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_prod <= PROD_W'(i_coef) * PROD_W'(i_x);
        end
    end

    assign o_x    = r_x;
    assign o_prod = r_prod;

endmodule

@@ src/cfr_sum.sv @@
module cfr_sum #(
    parameter int TAPS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cfr_pkg::t_prod     i_prod [TAPS],
    input  cfr_pkg::t_tag      i_tag,
    output logic               o_take,
    output logic               o_valid,
    input  logic               i_ready,
    output cfr_pkg::t_out_item o_item
);
    import cfr_pkg::*;

    localparam int NGRP  = (TAPS + 3) / 4;
    localparam int SUM_W = PROD_W + $clog2(TAPS) + 1;
    localparam logic signed [SUM_W-1:0] Q_MAX = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] Q_MIN = SUM_W'(-32768);
    localparam logic signed [SUM_W-1:0] RND   = SUM_W'(1 << (FRAC - 1));

    logic signed [SUM_W-1:0] r_grp [NGRP];
    logic signed [SUM_W-1:0] n_grp [NGRP];
    t_tag                    r_t2;
    t_tag                    r_t3;
    t_out_item               r_out;
    t_out_item               n_out;
    logic                    w_free3;
    logic                    w_free2;
    logic signed [SUM_W-1:0] w_acc;
    logic signed [SUM_W-1:0] w_q;

    // Stage moves when empty or when the one after it moves
    assign w_free3 = !r_t3.valid || i_ready;
    assign w_free2 = !r_t2.valid || w_free3;
    assign o_take  = w_free2;

    // Group sums of up to four products
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_grp[g] = '0;
            for (int j = 0; j < 4; j++) begin
                if (g * 4 + j < TAPS) begin
                    n_grp[g] = n_grp[g] + SUM_W'(i_prod[g * 4 + j]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t2 <= '0;
        end else if (w_free2) begin
            r_t2 <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_free2) begin
            r_grp <= n_grp;
        end
    end

    // Final add, round half up, drop 15 fraction bits, saturate
    always_comb begin
        w_acc = RND;
        for (int g = 0; g < NGRP; g++) begin
            w_acc = w_acc + r_grp[g];
        end
        w_q = w_acc >>> FRAC;
        n_out.block_end_out = r_t2.last;
        if (w_q > Q_MAX) begin
            n_out.sample_out = t_sample'(Q_MAX);
            n_out.clipped    = 1'b1;
        end else if (w_q < Q_MIN) begin
            n_out.sample_out = t_sample'(Q_MIN);
            n_out.clipped    = 1'b1;
        end else begin
            n_out.sample_out = t_sample'(w_q);
            n_out.clipped    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t3 <= '0;
        end else if (w_free3) begin
            r_t3 <= r_t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_free3) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_t3.valid;
    assign o_item  = r_out;

endmodule

@@ src/centered_fir_filter.sv @@
// Centered FIR over blocks of Q1.15 samples. One sample is taken per clock
// while the input is ready. The first TAPS/2 samples of a block produce no
// result; each later sample produces one, and the sample marked block_end also
// flushes up to TAPS/2 more results fed with zeros, one per clock unless the
// product stage holds, during which the input is not ready. A block of N samples
// therefore yields N results. A result is registered in turn as tap products,
// group sums, then final sum with round-half-up and saturation. Each stage holds
// under output backpressure and empty stages still fill, so input keeps flowing
// while a result waits until the stages are full. Coefficients must be written
// through the cfg port only while the block is idle, which the block leaves unchecked.
module centered_fir_filter #(
    parameter int TAPS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [cfr_pkg::CIDX_W-1:0]  i_cfg_idx,
    input  logic [cfr_pkg::SMP_W-1:0]   i_cfg_data,
    cfr_stream_if.sink                  i_in,
    cfr_stream_if.source                o_out
);
    import cfr_pkg::*;

    localparam int HALF = TAPS / 2;
    localparam int FW   = $clog2(HALF + 1);

    t_sample        r_coef [NCOEF];
    logic [FW-1:0]  r_fill;
    logic [FW-1:0]  n_fill;
    logic           r_flushing;
    logic [FW-1:0]  r_ft;
    logic [FW-1:0]  r_ff;
    t_tag           r_t1;
    t_in_item       w_in;
    logic           w_take;
    logic           w_free1;
    logic           w_accept;
    logic           w_step;
    logic           w_emit;
    logic           w_last;
    t_sample        w_x [TAPS+1];
    t_prod          w_prod [TAPS];
    t_out_item      w_out;

    assign w_in     = i_in.data;
    assign w_free1  = !r_t1.valid || w_take;
    assign i_in.ready = !r_flushing && w_free1;
    assign w_accept = i_in.valid && i_in.ready;
    assign w_step   = w_accept || (r_flushing && w_free1);

    // Coefficient registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NCOEF; k++) begin
                r_coef[k] <= '0;
            end
        end else if (i_cfg_we) begin
            r_coef[i_cfg_idx] <= t_sample'(i_cfg_data);
        end
    end

    // Step decode: does this step produce a result, is it the block's last
    always_comb begin
        w_emit = 1'b0;
        w_last = 1'b0;
        n_fill = r_fill;
        if (r_flushing) begin
            w_emit = ((FW + 1)'(r_ft) + (FW + 1)'(r_ff)) >= (FW + 1)'(HALF);
            w_last = (r_ft == FW'(HALF));
        end else if (w_accept) begin
            w_emit = (r_fill == FW'(HALF));
            if (w_in.block_end) begin
                n_fill = '0;
            end else if (!w_emit) begin
                n_fill = r_fill + FW'(1);
            end
        end
    end

    // Fill count and flush sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_flushing <= 1'b0;
            r_ft       <= '0;
            r_ff       <= '0;
        end else if (w_step) begin
            r_fill <= n_fill;
            if (r_flushing) begin
                if (w_last) begin
                    r_flushing <= 1'b0;
                end
                r_ft <= r_ft + FW'(1);
            end else if (w_in.block_end) begin
                r_flushing <= 1'b1;
                r_ft       <= FW'(1);
                r_ff       <= r_fill;
            end
        end
    end

    // Product stage tag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1 <= '0;
        end else if (w_free1) begin
            r_t1.valid <= w_step && w_emit;
            r_t1.last  <= w_last;
        end
    end

    // Sample chain: new sample enters cell 0, zeros during flush
    assign w_x[0] = w_accept ? w_in.sample_in : '0;

    for (genvar k = 0; k < TAPS; k++) begin : g_cell
        cfr_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_step  (w_step),
            .i_clear (w_last),
            .i_coef  (r_coef[k]),
            .i_x     (w_x[k]),
            .o_x     (w_x[k+1]),
            .o_prod  (w_prod[k])
        );
    end

    cfr_sum #(
        .TAPS (TAPS)
    ) u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_prod  (w_prod),
        .i_tag   (r_t1),
        .o_take  (w_take),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_item  (w_out)
    );

    assign o_out.data = w_out;

endmodule

@@ src/cfr_chk.sv @@
`include "assert_macros.svh"

module cfr_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_end,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_out_sample,
    input logic        i_out_clipped
);

    // Flush follows a block end, so input must not be taken on the next clock
    `CFR_ASSERT_NXT(a_end_flush, i_clk, i_rst_n, i_in_valid && i_in_ready && i_in_end, !i_in_ready, "input taken right after block end")

    // A clipped result sits on a rail
    `CFR_ASSERT_IMP(a_clip_rail, i_clk, i_rst_n, i_out_valid && i_out_clipped, i_out_sample == 16'h7fff || i_out_sample == 16'h8000, "clipped result not saturated")

    // Stalled output transaction holds
    `CFR_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_sample), "stalled output changed")

endmodule

bind centered_fir_filter cfr_chk u_cfr_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_in_end      (i_in.data.block_end),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_sample  (o_out.data.sample_out),
    .i_out_clipped (o_out.data.clipped)
);

@@ sim/centered_fir_filter_test.sv @@
module centered_fir_filter_test;
    import cfr_pkg::*;

    localparam int TAPS        = 8;
    localparam int HALF        = TAPS / 2;
    localparam int HDEPTH      = 7;
    localparam int SET_ITEMS   = 73;    // random samples per coefficient set
    localparam int RAND_SETS   = 6;
    localparam int SETTLE_CYC  = 8;     // pipeline depth plus margin
    localparam int LONG_HOLD   = 300;
    localparam int QUIET_LIMIT = 2000;
    localparam int NDIR        = 23;

    // One queued sample plus an optional literal result for all it causes
    typedef struct packed {
        t_in_item item;
        logic     fixed;
        t_sample  fval;
        logic     fclip;
    } t_feed;

    typedef struct packed {
        logic [1:0] phase;
        t_sample    smp;
        logic       last;
        logic       fixed;
        t_sample    fval;
        logic       fclip;
    } t_dir_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CIDX_W-1:0]   i_cfg_idx;
    logic [SMP_W-1:0]    i_cfg_data;

    cfr_stream_if #(.T(t_in_item))  in_ch ();
    cfr_stream_if #(.T(t_out_item)) out_ch ();

    centered_fir_filter #(.TAPS(TAPS)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // Predictor state
    t_sample coef_set [NCOEF];
    t_sample pending_coef [NCOEF];
    t_sample hist [HDEPTH] = '{default: '0};
    int      fill;

    t_feed     feed_q [$];
    t_feed     wire_meta;
    t_out_item filtered_due_q [$];

    int  feeds_queued, feeds_taken;
    int  n_blocks, n_out, n_clip, n_sets, errs, quiet;
    int  gap_left, hold_left;
    bit  in_gaps_on, out_gaps_on, stall_long_req, long_done;

    t_dir_row dir_rows [NDIR];

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Filter arithmetic: exact Q2.30 sum, round half up, saturate to Q1.15
    function automatic t_out_item tap_sum(t_sample cur, logic last);
        longint    acc;
        longint    r;
        t_out_item o;
        acc = longint'(coef_set[0]) * longint'(cur);
        for (int k = 1; k < TAPS; k++)
            acc += longint'(coef_set[k]) * longint'(hist[k-1]);
        acc += 16384;
        r = acc >>> FRAC;
        o.clipped = 1'b0;
        if (r > 32767) begin
            r = 32767;
            o.clipped = 1'b1;
        end else if (r < -32768) begin
            r = -32768;
            o.clipped = 1'b1;
        end
        o.sample_out    = r[15:0];
        o.block_end_out = last;
        return o;
    endfunction

    function automatic void shift_hist(t_sample v);
        for (int k = HDEPTH - 1; k >= 1; k--)
            hist[k] = hist[k-1];
        hist[0] = v;
    endfunction

    task automatic queue_due(t_out_item o, t_feed meta);
        if (meta.fixed) begin
            o.sample_out = meta.fval;
            o.clipped    = meta.fclip;
        end
        filtered_due_q.push_back(o);
    endtask

    // Expected results of one accepted sample
    task automatic fir_predict(t_in_item it, t_feed meta);
        t_sample v;
        int      f;
        f = fill;
        if (!it.block_end) begin
            if (f == HALF)
                queue_due(tap_sum(it.sample_in, 1'b0), meta);
            else
                fill++;
            shift_hist(it.sample_in);
        end else begin
            // last sample, then zeros to flush the centered window
            for (int t = 0; t <= HALF; t++) begin
                v = (t == 0) ? it.sample_in : t_sample'(0);
                if (t >= HALF - f)
                    queue_due(tap_sum(v, t == HALF), meta);
                shift_hist(v);
            end
            foreach (hist[k]) hist[k] = '0;
            fill = 0;
        end
    endtask

    task automatic report(string what, int got, int want);
        $display("MISMATCH %s: got %0d, want %0d (result %0d)", what, got, want, n_out);
        errs++;
    endtask

    function automatic int pick_gap(bit on);
        int r;
        if (!on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_sample pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 16'sh7FFF;
        if (r < 16)
            return 16'sh8000;
        if (r < 36)
            return t_sample'(int'($urandom_range(0, 128)) - 64);
        return t_sample'($urandom());
    endfunction

    task automatic queue_feed(t_sample s, logic last, logic fixed, t_sample fv, logic fc);
        t_feed f;
        f.item.sample_in = s;
        f.item.block_end = last;
        f.fixed          = fixed;
        f.fval           = fv;
        f.fclip          = fc;
        feed_q.push_back(f);
        feeds_queued++;
    endtask

    // Wait until every sample is taken and every result is back, then let the pipe empty
    task automatic settle();
        do @(posedge i_clk);
        while (feeds_taken != feeds_queued || filtered_due_q.size() != 0);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_coefs();
        for (int k = 0; k < NCOEF; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_idx   <= k[CIDX_W-1:0];
            i_cfg_data  <= pending_coef[k];
            coef_set[k] = pending_coef[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        n_sets++;
    endtask

    // Sender: offers queued samples with random gaps between transactions
    initial begin
        t_feed f;
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;
        gap_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && (!in_ch.valid || in_ch.ready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_ch.valid <= 1'b0;
                end else if (feed_q.size() > 0) begin
                    f = feed_q.pop_front();
                    in_ch.data  <= f.item;
                    wire_meta   <= f;
                    in_ch.valid <= 1'b1;
                    gap_left = pick_gap(in_gaps_on);
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        out_ch.ready <= 1'b0;
        hold_left = 0;
        long_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                out_ch.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (stall_long_req && !long_done) begin
                long_done = 1'b1;
                hold_left = LONG_HOLD - 1;
                out_ch.ready <= 1'b0;
            end else begin
                hold_left = pick_gap(out_gaps_on);
                if (hold_left > 0) begin
                    hold_left--;
                    out_ch.ready <= 1'b0;
                end else begin
                    out_ch.ready <= 1'b1;
                end
            end
        end
    end

    // Input monitor: run the predictor on every accepted transaction
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            fir_predict(in_ch.data, wire_meta);
            feeds_taken++;
            if (in_ch.data.block_end)
                n_blocks++;
        end
    end

    // Output checker: compare each result with the oldest pending one
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            n_out++;
            if (out_ch.data.clipped)
                n_clip++;
            if (filtered_due_q.size() == 0) begin
                report("result with none pending", int'(out_ch.data.sample_out), 0);
            end else begin
                want = filtered_due_q.pop_front();
                if (out_ch.data.sample_out !== want.sample_out)
                    report("sample_out", int'(out_ch.data.sample_out), int'(want.sample_out));
                if (out_ch.data.clipped !== want.clipped)
                    report("clipped", int'(out_ch.data.clipped), int'(want.clipped));
                if (out_ch.data.block_end_out !== want.block_end_out)
                    report("block_end_out", int'(out_ch.data.block_end_out),
                           int'(want.block_end_out));
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT) begin
            $display("timeout after %0d idle cycles, %0d results pending",
                     quiet, filtered_due_q.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        int       cur_phase;
        int       left, blen, kind, sel;
        t_dir_row row;

        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        foreach (coef_set[k]) coef_set[k] = '0;
        feeds_queued = 0;
        n_sets = 0;
        stall_long_req = 1'b0;
        in_gaps_on = 1'b1;
        out_gaps_on = 1'b1;

        // Directed rows: reset coefficients, full-scale saturation, half-up ties,
        // short blocks
        dir_rows = '{
            '{2'd0, 16'sh7FFF, 1'b0, 1'b1, 16'sh0000, 1'b0},
            '{2'd0, 16'sh8000, 1'b0, 1'b1, 16'sh0000, 1'b0},
            '{2'd0, 16'sh5555, 1'b0, 1'b1, 16'sh0000, 1'b0},
            '{2'd0, 16'shFFFF, 1'b0, 1'b1, 16'sh0000, 1'b0},
            '{2'd0, 16'sh2AAA, 1'b0, 1'b1, 16'sh0000, 1'b0},
            '{2'd0, 16'sh0007, 1'b1, 1'b1, 16'sh0000, 1'b0},
            '{2'd1, 16'sh8000, 1'b0, 1'b1, 16'sh7FFF, 1'b1},
            '{2'd1, 16'sh8000, 1'b0, 1'b1, 16'sh7FFF, 1'b1},
            '{2'd1, 16'sh8000, 1'b0, 1'b1, 16'sh7FFF, 1'b1},
            '{2'd1, 16'sh8000, 1'b0, 1'b1, 16'sh7FFF, 1'b1},
            '{2'd1, 16'sh8000, 1'b0, 1'b1, 16'sh7FFF, 1'b1},
            '{2'd1, 16'sh8000, 1'b0, 1'b1, 16'sh7FFF, 1'b1},
            '{2'd1, 16'sh8000, 1'b0, 1'b1, 16'sh7FFF, 1'b1},
            '{2'd1, 16'sh8000, 1'b1, 1'b1, 16'sh7FFF, 1'b1},
            '{2'd1, 16'sh7FFF, 1'b1, 1'b0, 16'sh0000, 1'b0},
            '{2'd2, 16'sh0001, 1'b0, 1'b0, 16'sh0000, 1'b0},
            '{2'd2, 16'shFFFF, 1'b0, 1'b0, 16'sh0000, 1'b0},
            '{2'd2, 16'sh0003, 1'b0, 1'b0, 16'sh0000, 1'b0},
            '{2'd2, 16'shFFFD, 1'b0, 1'b0, 16'sh0000, 1'b0},
            '{2'd2, 16'sh7FFF, 1'b1, 1'b0, 16'sh0000, 1'b0},
            '{2'd2, 16'sh0005, 1'b1, 1'b0, 16'sh0000, 1'b0},
            '{2'd2, 16'sh8000, 1'b0, 1'b0, 16'sh0000, 1'b0},
            '{2'd2, 16'sh7FFF, 1'b1, 1'b0, 16'sh0000, 1'b0}
        };

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part; set 0 keeps the reset coefficients
        cur_phase = 0;
        foreach (dir_rows[r]) begin
            row = dir_rows[r];
            if (int'(row.phase) != cur_phase) begin
                settle();
                cur_phase = int'(row.phase);
                for (int k = 0; k < NCOEF; k++)
                    pending_coef[k] = (cur_phase == 1) ? 16'sh8000 :
                                      (k == HALF) ? 16'sh4000 : 16'sh0000;
                write_coefs();
            end
            queue_feed(row.smp, row.last, row.fixed, row.fval, row.fclip);
        end

        // Random part: one coefficient set per pass, blocks of random length
        for (int p = 0; p < RAND_SETS; p++) begin
            settle();
            kind = p % 5;
            sel = $urandom_range(0, NCOEF - 1);
            for (int k = 0; k < NCOEF; k++) begin
                case (kind)
                    1: pending_coef[k] = 16'sh7FFF;
                    2: pending_coef[k] = 16'sh8000;
                    3: pending_coef[k] = t_sample'(int'($urandom_range(0, 6000)) - 3000);
                    4: pending_coef[k] = (k != sel) ? 16'sh0000 :
                                         ($urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000);
                    default: pending_coef[k] = t_sample'($urandom());
                endcase
            end
            write_coefs();
            in_gaps_on  = (p % 3) != 1;
            out_gaps_on = (p % 3) != 2;
            if (p == 2)
                stall_long_req = 1'b1;
            left = SET_ITEMS;
            while (left > 0) begin
                blen = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 10)
                                                    : $urandom_range(11, 30);
                if (blen > left)
                    blen = left;
                for (int i = 0; i < blen; i++)
                    queue_feed(pick_sample(), i == blen - 1, 1'b0, 16'sh0000, 1'b0);
                left -= blen;
            end
        end

        settle();
        $display("covered %0d samples in %0d blocks under %0d coefficient sets",
                 feeds_taken, n_blocks, n_sets + 1);
        $display("checked %0d results, %0d saturated, %0d failures", n_out, n_clip, errs);
        if (errs == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
